// ===== src/srwf_pkg.sv =====
// Shared types and constants for the star record window filter.
`default_nettype none

package srwf_pkg;

  // Field widths.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RA_W     = 27;
  localparam int unsigned POLAR_W  = 26;
  localparam int unsigned INDEX_W  = 26;
  localparam int unsigned ZONE_W   = 11;
  localparam int unsigned MAG_W    = 10;
  localparam int unsigned QFLAG_W  = 4;
  localparam int unsigned CFG_W    = 27;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned S_DATA_W = 128;
  localparam int unsigned M_DATA_W = 128;

  // Widths of the quotients of the absolute magnitude by 1000 and 1000000.
  localparam int unsigned Q1_W = 22;  // |mag| / 1000, at most 2147483
  localparam int unsigned Q2_W = 12;  // |mag| / 1000000, at most 2147

  // Decimal constants.
  localparam logic [MAG_W-1:0] MAG_NO_RED  = 10'd999;
  localparam logic [11:0]      THOUSAND    = 12'd1000;
  localparam logic [11:0]      TWO_THOUSAND = 12'd2000;

  // Reciprocals of 1000: floor(x * RECIP / 2^SHIFT) equals x / 1000 over the
  // value range each one is used on.
  localparam logic [31:0] RECIP_A     = 32'd2199023256;  // ceil(2^41 / 1000)
  localparam int unsigned RECIP_A_SH  = 41;
  localparam logic [22:0] RECIP_B     = 23'd4294968;     // ceil(2^32 / 1000)
  localparam int unsigned RECIP_B_SH  = 32;

  // Reset values of the configuration registers.
  localparam logic [RA_W-1:0]    RA_HIGH_RST    = 27'd129600000;
  localparam logic [POLAR_W-1:0] POLAR_HIGH_RST = 26'd64800000;
  localparam logic [MAG_W-1:0]   RED_HIGH_RST   = 10'd999;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RA_LOW       = 3'd0,
    REG_RA_HIGH      = 3'd1,
    REG_RA_WRAPS     = 3'd2,
    REG_POLAR_LOW    = 3'd3,
    REG_POLAR_HIGH   = 3'd4,
    REG_RED_MAG_LOW  = 3'd5,
    REG_RED_MAG_HIGH = 3'd6,
    REG_ZONE_CODE    = 3'd7
  } reg_idx_t;

  // Current configuration.
  typedef struct packed {
    logic [RA_W-1:0]    ra_low;
    logic [RA_W-1:0]    ra_high;
    logic               ra_wraps;
    logic [POLAR_W-1:0] polar_low;
    logic [POLAR_W-1:0] polar_high;
    logic [MAG_W-1:0]   red_mag_low;
    logic [MAG_W-1:0]   red_mag_high;
    logic [ZONE_W-1:0]  zone_code;
  } cfg_t;

  // Record after byte swap and coordinate window test.
  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic [RA_W-1:0]    ra;
    logic [POLAR_W-1:0] polar;
    logic               neg;
    logic [WORD_W-1:0]  abs_mag;
  } coord_t;

  // Fields carried unchanged down the digit pipeline.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [RA_W-1:0]    ra;
    logic [POLAR_W-1:0] polar;
    logic               neg;
  } carry_t;

  // Decimal digits of the magnitude word, with the carried fields.
  typedef struct packed {
    carry_t             carry;
    logic [QFLAG_W-1:0] qflag;
    logic [MAG_W-1:0]   fff;
    logic [MAG_W-1:0]   bbb;
    logic [MAG_W-1:0]   rrr;
  } digits_t;

endpackage

`default_nettype wire

// ===== src/srwf_cfg_regs.sv =====
// Configuration registers of the star record window filter.
`default_nettype none

module srwf_cfg_regs
  import srwf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_next;

  // Decode a write into the addressed register.
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_RA_LOW:       cfg_next.ra_low       = cfg_data[RA_W-1:0];
        REG_RA_HIGH:      cfg_next.ra_high      = cfg_data[RA_W-1:0];
        REG_RA_WRAPS:     cfg_next.ra_wraps     = cfg_data[0];
        REG_POLAR_LOW:    cfg_next.polar_low    = cfg_data[POLAR_W-1:0];
        REG_POLAR_HIGH:   cfg_next.polar_high   = cfg_data[POLAR_W-1:0];
        REG_RED_MAG_LOW:  cfg_next.red_mag_low  = cfg_data[MAG_W-1:0];
        REG_RED_MAG_HIGH: cfg_next.red_mag_high = cfg_data[MAG_W-1:0];
        REG_ZONE_CODE:    cfg_next.zone_code    = cfg_data[ZONE_W-1:0];
        default:          cfg_next = cfg;
      endcase
    end
  end

  // Register file with reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ra_low       <= '0;
      cfg.ra_high      <= RA_HIGH_RST;
      cfg.ra_wraps     <= 1'b0;
      cfg.polar_low    <= '0;
      cfg.polar_high   <= POLAR_HIGH_RST;
      cfg.red_mag_low  <= '0;
      cfg.red_mag_high <= RED_HIGH_RST;
      cfg.zone_code    <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/srwf_coord_check.sv =====
// Byte swap of the record words, coordinate window test and magnitude abs.
`default_nettype none

module srwf_coord_check
  import srwf_pkg::*;
(
  input  wire logic [WORD_W-1:0]  ra_word,
  input  wire logic [WORD_W-1:0]  polar_word,
  input  wire logic [WORD_W-1:0]  mag_word,
  input  wire logic [INDEX_W-1:0] record_index,
  input  wire cfg_t               cfg,
  output coord_t                  coord
);

  logic [WORD_W-1:0] ra;
  logic [WORD_W-1:0] polar;
  logic [WORD_W-1:0] mag;
  logic              ra_ge_low;
  logic              ra_le_high;
  logic              ra_ok;
  logic              polar_ok;

  // Big-endian words to native order.
  assign ra    = {ra_word[7:0], ra_word[15:8], ra_word[23:16], ra_word[31:24]};
  assign polar = {polar_word[7:0], polar_word[15:8], polar_word[23:16],
                  polar_word[31:24]};
  assign mag   = {mag_word[7:0], mag_word[15:8], mag_word[23:16], mag_word[31:24]};

  // Signed compares against unsigned bounds: a negative value is below any
  // low bound and below any high bound.
  assign ra_ge_low  = !ra[31] && (ra[30:0] >= 31'(cfg.ra_low));
  assign ra_le_high = ra[31] || (ra[30:0] <= 31'(cfg.ra_high));
  assign ra_ok      = cfg.ra_wraps ? (ra_ge_low || ra_le_high)
                                   : (ra_ge_low && ra_le_high);
  assign polar_ok   = !polar[31] && (polar[30:0] >= 31'(cfg.polar_low))
                                 && (polar[30:0] <= 31'(cfg.polar_high));

  // Result fields; the most negative magnitude gives 2^31 exactly.
  always_comb begin
    coord.keep    = ra_ok && polar_ok;
    coord.index   = record_index;
    coord.ra      = ra[RA_W-1:0];
    coord.polar   = polar[POLAR_W-1:0];
    coord.neg     = mag[31];
    coord.abs_mag = mag[31] ? (~mag + 32'd1) : mag;
  end

endmodule

`default_nettype wire

// ===== src/srwf_mag_split.sv =====
// Four-stage pipeline that splits the absolute magnitude into decimal digits.
`default_nettype none

module srwf_mag_split
  import srwf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire coord_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output digits_t     out_data
);

  // Stage registers.
  logic              v1, v2, v3, v4;
  logic              r1, r2, r3, r4;
  carry_t            c1, c2, c3;
  logic [WORD_W-1:0] a1, a2;
  logic [Q1_W-1:0]   q1_2, q1_3;
  logic [Q2_W-1:0]   q2_3;
  logic [MAG_W-1:0]  rrr_3;
  digits_t           d4;

  // Stage datapath values.
  logic [63:0]       prod_a;
  logic [Q1_W-1:0]   q1_calc;
  logic [44:0]       prod_b;
  logic [Q2_W-1:0]   q2_calc;
  logic [WORD_W-1:0] rrr_wide;
  logic [Q1_W-1:0]   bbb_wide;
  logic [1:0]        q_digit;
  logic [Q2_W-1:0]   q_times;
  logic [Q2_W-1:0]   fff_wide;

  // A stage takes a new request when it is empty or its content moves on.
  assign r4        = !v4 || out_ready;
  assign r3        = !v3 || r4;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v4;
  assign out_data  = d4;

  // Stage 2 math: |mag| / 1000 by reciprocal multiply.
  assign prod_a  = 64'(a1) * 64'(RECIP_A);
  assign q1_calc = prod_a[RECIP_A_SH +: Q1_W];

  // Stage 3 math: low digits and |mag| / 1000000.
  assign rrr_wide = a2 - (32'(q1_2) * 32'(THOUSAND));
  assign prod_b   = 45'(q1_2) * 45'(RECIP_B);
  assign q2_calc  = prod_b[RECIP_B_SH +: Q2_W];

  // Stage 4 math: middle digits, plate field and quality digit.
  assign bbb_wide = q1_3 - (22'(q2_3) * 22'(THOUSAND));
  always_comb begin
    if (q2_3 >= TWO_THOUSAND) begin
      q_digit = 2'd2;
      q_times = TWO_THOUSAND;
    end else if (q2_3 >= THOUSAND) begin
      q_digit = 2'd1;
      q_times = THOUSAND;
    end else begin
      q_digit = 2'd0;
      q_times = '0;
    end
  end
  assign fff_wide = q2_3 - q_times;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (r1) begin
      c1 <= '{index: in_data.index, ra: in_data.ra, polar: in_data.polar,
              neg: in_data.neg};
      a1 <= in_data.abs_mag;
    end
    if (r2) begin
      c2   <= c1;
      a2   <= a1;
      q1_2 <= q1_calc;
    end
    if (r3) begin
      c3    <= c2;
      q1_3  <= q1_2;
      q2_3  <= q2_calc;
      rrr_3 <= rrr_wide[MAG_W-1:0];
    end
    if (r4) begin
      d4.carry <= c3;
      d4.qflag <= QFLAG_W'(q_digit);
      d4.fff   <= fff_wide[MAG_W-1:0];
      d4.bbb   <= bbb_wide[MAG_W-1:0];
      d4.rrr   <= rrr_3;
    end
  end

  // The reciprocal products must leave every digit group below 1000.
  a_low_digits: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (rrr_wide < 32'(THOUSAND)))
    else $error("low digit group out of range");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (d4.fff <= MAG_NO_RED) && (d4.bbb <= MAG_NO_RED)
           && (d4.rrr <= MAG_NO_RED) && (d4.qflag <= 4'd2))
    else $error("decimal digit group out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !out_ready |=> v4 && $stable(d4))
    else $error("digit stage lost a stalled request");

endmodule

`default_nettype wire

// ===== src/star_record_window_filter_unit.sv =====
// Top level of the star record window filter.
//
// Records enter on the s_ stream: one request per catalog star, holding the
// three big-endian record words and the record index. Each record is byte
// swapped and tested against the RA, polar distance and red magnitude
// windows; a kept record leaves as one request on the m_ stream, a rejected
// one leaves nothing. The window registers are written through the cfg_
// port and should change only while no record is in flight.
//
// The datapath is six register stages deep: input register, four digit
// split stages and the output register. One record is taken every cycle
// while the receiver does not stall, since every stage hands its request
// on in each cycle that the next one is free.
//
// Reset restores the window registers to their reset values and empties
// every stage. When the receiver stalls, the output register holds its
// request and the stages behind it keep filling, so s_tready stays high
// until every stage holds a request.
`default_nettype none

module star_record_window_filter_unit
  import srwf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Input stream.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // From bit 0: ra_word[31:0], polar_word[31:0], mag_word[31:0],
  // record_index[25:0], zero fill.
  input  wire logic [S_DATA_W-1:0]  s_tdata,
  // Output stream.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // From bit 0: zone_out[10:0], index_out[25:0], ra_cas[26:0],
  // polar_cas[25:0], act_sign, quality_flag[3:0], plate_field[9:0],
  // blue_mag[9:0], red_mag[9:0], zero fill.
  output logic [M_DATA_W-1:0]       m_tdata,
  // Configuration write port.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t              cfg;
  logic              in_valid;
  logic              in_ready;
  logic [WORD_W-1:0] ra_word;
  logic [WORD_W-1:0] polar_word;
  logic [WORD_W-1:0] mag_word;
  logic [INDEX_W-1:0] record_index;
  coord_t            coord;
  logic              split_in_valid;
  logic              split_in_ready;
  logic              split_valid;
  logic              split_ready;
  digits_t           digits;
  logic [MAG_W-1:0]  red_sel;
  logic [MAG_W-1:0]  blue_sel;
  logic              mag_ok;
  logic              out_valid;
  logic [M_DATA_W-1:0] out_data;

  srwf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  assign in_ready = !in_valid || split_in_ready;
  assign s_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      ra_word      <= s_tdata[31:0];
      polar_word   <= s_tdata[63:32];
      mag_word     <= s_tdata[95:64];
      record_index <= s_tdata[121:96];
    end
  end

  srwf_coord_check u_coord_check (
    .ra_word      (ra_word),
    .polar_word   (polar_word),
    .mag_word     (mag_word),
    .record_index (record_index),
    .cfg          (cfg),
    .coord        (coord)
  );

  // Records outside the coordinate windows are dropped here.
  assign split_in_valid = in_valid && coord.keep;

  srwf_mag_split u_mag_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_in_valid),
    .in_ready  (split_in_ready),
    .in_data   (coord),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (digits)
  );

  // Magnitude fallback rules and red magnitude window.
  assign red_sel  = (digits.rrr == MAG_NO_RED) ? digits.bbb : digits.rrr;
  assign blue_sel = ((digits.bbb == '0) && (digits.fff == '0)) ? digits.rrr
                                                              : digits.bbb;
  assign mag_ok   = (red_sel >= cfg.red_mag_low) && (red_sel <= cfg.red_mag_high);

  // Output register.
  assign split_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (split_ready) begin
      out_valid <= split_valid && mag_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (split_ready) begin
      out_data <= {3'b000, red_sel, blue_sel, digits.fff, digits.qflag,
                   digits.carry.neg, digits.carry.polar, digits.carry.ra,
                   digits.carry.index, cfg.zone_code};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Every stage is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !in_valid)
    else $error("output not empty after reset");

  // A stalled result must not be replaced or dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The input side only stalls when the input register cannot drain.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && !split_in_ready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the star record window filter with a stream driver and monitor.

module tb_top;
  import srwf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned DRAIN_GUARD  = 50000;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned RA_TOP       = 129600000;
  localparam int unsigned POLAR_TOP    = 64800000;

  // One catalog record as it travels on s_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [INDEX_W-1:0] record_index;
    logic [WORD_W-1:0]  mag_word;
    logic [WORD_W-1:0]  polar_word;
    logic [WORD_W-1:0]  ra_word;
  } star_rec_t;

  // One kept star as it travels on m_tdata, last member in the lowest bits.
  typedef struct packed {
    logic [MAG_W-1:0]   red_mag;
    logic [MAG_W-1:0]   blue_mag;
    logic [MAG_W-1:0]   plate_field;
    logic [QFLAG_W-1:0] quality_flag;
    logic               act_sign;
    logic [POLAR_W-1:0] polar_cas;
    logic [RA_W-1:0]    ra_cas;
    logic [INDEX_W-1:0] index_out;
    logic [ZONE_W-1:0]  zone_out;
  } star_res_t;

  localparam int unsigned S_FILL = S_DATA_W - $bits(star_rec_t);

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Window settings as the block should currently hold them.
  cfg_t win_cfg;

  star_rec_t   pending_recs[$];
  star_res_t   expected_stars[$];
  logic        took_in = 1'b0;
  logic        took_out = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned src_wait = 0;
  int unsigned snk_wait = 0;
  int unsigned mismatch_count = 0;
  int unsigned records_sent = 0;
  int unsigned stars_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 1;

  star_record_window_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Byte order reversal; it is its own inverse.
  function automatic logic [31:0] swap32(input logic [31:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Works out whether a record is kept under the given windows, and its fields.
  function automatic bit predict_kept_star(input star_rec_t rec, input cfg_t c,
                                           output star_res_t res);
    logic signed [31:0] sw;
    longint ra_v, spd_v, mag_v, a;
    longint rrr, bbb, fff, q, red, blue;
    bit ra_ok;
    res = '0;
    sw = swap32(rec.ra_word);
    ra_v = sw;
    sw = swap32(rec.polar_word);
    spd_v = sw;
    sw = swap32(rec.mag_word);
    mag_v = sw;
    if (c.ra_wraps) begin
      ra_ok = (ra_v >= longint'(c.ra_low)) || (ra_v <= longint'(c.ra_high));
    end else begin
      ra_ok = (ra_v >= longint'(c.ra_low)) && (ra_v <= longint'(c.ra_high));
    end
    if (!ra_ok) return 1'b0;
    if (spd_v < longint'(c.polar_low) || spd_v > longint'(c.polar_high)) return 1'b0;
    // Split |mag| into the decimal digit groups Q FFF BBB RRR.
    a = (mag_v < 0) ? -mag_v : mag_v;
    rrr = a % 1000;
    bbb = (a / 1000) % 1000;
    fff = (a / 1000000) % 1000;
    q = (a / 1000000000) % 10;
    red = (rrr == longint'(MAG_NO_RED)) ? bbb : rrr;
    if (red < longint'(c.red_mag_low) || red > longint'(c.red_mag_high)) return 1'b0;
    blue = (bbb == 0 && fff == 0) ? rrr : bbb;
    res.zone_out     = c.zone_code;
    res.index_out    = rec.record_index;
    res.ra_cas       = ra_v[RA_W-1:0];
    res.polar_cas    = spd_v[POLAR_W-1:0];
    res.act_sign     = (mag_v < 0);
    res.quality_flag = q[QFLAG_W-1:0];
    res.plate_field  = fff[MAG_W-1:0];
    res.blue_mag     = blue[MAG_W-1:0];
    res.red_mag      = red[MAG_W-1:0];
    return 1'b1;
  endfunction

  // Prints one mismatch line, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s of kept record %0d: got %0d, expected %0d",
                                name, stars_checked, got, want));
    end
  endtask

  // Queues a record given as coordinate and magnitude values before the byte swap.
  task automatic queue_rec(input longint ra, input longint spd, input longint mag,
                           input int unsigned idx);
    star_rec_t rec;
    rec.ra_word      = swap32(ra[31:0]);
    rec.polar_word   = swap32(spd[31:0]);
    rec.mag_word     = swap32(mag[31:0]);
    rec.record_index = idx[INDEX_W-1:0];
    pending_recs.push_back(rec);
  endtask

  // Coordinate close to the window edges, inside it, or anywhere in range.
  function automatic longint pick_coord(input int unsigned lo, input int unsigned hi,
                                        input int unsigned top);
    longint d;
    d = longint'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0: pick_coord = longint'(lo) + d;
      1: pick_coord = longint'(hi) + d;
      2, 3: pick_coord = longint'($urandom_range(lo, hi));
      default: pick_coord = longint'($urandom_range(0, top)) + d;
    endcase
  endfunction

  // Mostly well-formed records aimed at the current windows, the rest raw noise.
  task automatic queue_random_rec();
    star_rec_t rec;
    longint ra, spd, a, rv;
    longint q, f, b, r;
    int unsigned idx;
    idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 200000);
    if ($urandom_range(0, 4) == 0) begin
      rec.ra_word      = $urandom;
      rec.polar_word   = $urandom;
      rec.mag_word     = $urandom;
      rec.record_index = idx[INDEX_W-1:0];
      pending_recs.push_back(rec);
    end else begin
      ra  = pick_coord(win_cfg.ra_low, win_cfg.ra_high, RA_TOP);
      spd = pick_coord(win_cfg.polar_low, win_cfg.polar_high, POLAR_TOP);
      q = $urandom_range(0, 2);
      f = $urandom_range(0, 999);
      b = $urandom_range(0, 999);
      case ($urandom_range(0, 7))
        0: r = 999;
        1: rv = longint'(win_cfg.red_mag_low) + longint'($urandom_range(0, 4)) - 2;
        2: rv = longint'(win_cfg.red_mag_high) + longint'($urandom_range(0, 4)) - 2;
        default: r = $urandom_range(0, 999);
      endcase
      if (r != 999 && rv != 0) begin
        r = (rv < 0) ? 0 : (rv > 998) ? 998 : rv;
      end
      // Empty blue digits, sometimes with an empty plate field too.
      if ($urandom_range(0, 7) == 0) begin
        b = 0;
        if ($urandom_range(0, 1)) f = 0;
      end
      a = q * 1000000000 + f * 1000000 + b * 1000 + r;
      if (a > 2147483647) a -= 1000000000;
      queue_rec(ra, spd, $urandom_range(0, 1) ? -a : a, idx);
    end
  endtask

  // Register write at a falling edge; the model copy is updated once the write is clocked in.
  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_RA_LOW:       win_cfg.ra_low       = val[RA_W-1:0];
      REG_RA_HIGH:      win_cfg.ra_high      = val[RA_W-1:0];
      REG_RA_WRAPS:     win_cfg.ra_wraps     = val[0];
      REG_POLAR_LOW:    win_cfg.polar_low    = val[POLAR_W-1:0];
      REG_POLAR_HIGH:   win_cfg.polar_high   = val[POLAR_W-1:0];
      REG_RED_MAG_LOW:  win_cfg.red_mag_low  = val[MAG_W-1:0];
      REG_RED_MAG_HIGH: win_cfg.red_mag_high = val[MAG_W-1:0];
      REG_ZONE_CODE:    win_cfg.zone_code    = val[ZONE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_windows(input int unsigned ra_lo, input int unsigned ra_hi,
                               input int unsigned wraps, input int unsigned p_lo,
                               input int unsigned p_hi, input int unsigned r_lo,
                               input int unsigned r_hi, input int unsigned zone);
    write_reg(REG_RA_LOW, ra_lo);
    write_reg(REG_RA_HIGH, ra_hi);
    write_reg(REG_RA_WRAPS, wraps);
    write_reg(REG_POLAR_LOW, p_lo);
    write_reg(REG_POLAR_HIGH, p_hi);
    write_reg(REG_RED_MAG_LOW, r_lo);
    write_reg(REG_RED_MAG_HIGH, r_hi);
    write_reg(REG_ZONE_CODE, zone);
    settings_used++;
  endtask

  // Waits until every record is sent and every kept star has come out, then
  // lets rejected records still in the pipeline run out.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while ((pending_recs.size() != 0 || s_tvalid || expected_stars.size() != 0) &&
           guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed records at reset settings, then phases of random records.
  initial begin : stimulus
    int unsigned p, n_items;
    int unsigned ra_lo, ra_hi, wraps, p_lo, p_hi, r_lo, r_hi, zone;
    win_cfg = '{ra_low: '0, ra_high: RA_HIGH_RST, ra_wraps: 1'b0, polar_low: '0,
                polar_high: POLAR_HIGH_RST, red_mag_low: '0,
                red_mag_high: RED_HIGH_RST, zone_code: '0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Edges of the RA and polar windows, negative values and the magnitude digit rules.
    queue_rec(0, 0, 0, 1);
    queue_rec(RA_TOP, POLAR_TOP, 999, 67108863);
    queue_rec(RA_TOP + 1, 100, 5, 2);
    queue_rec(100, POLAR_TOP + 1, 5, 3);
    queue_rec(-1, 100, 5, 4);
    queue_rec(100, -5, 5, 5);
    queue_rec(5000, 6000, -2147483648, 6);
    queue_rec(5000, 6000, -1, 7);
    queue_rec(5000, 6000, 2147483647, 8);
    queue_rec(5000, 6000, 1999999999, 9);
    queue_rec(5000, 6000, 500, 10);
    queue_rec(5000, 6000, 5123999, 11);
    queue_rec(5000, 6000, 123000999, 12);
    queue_rec(5000, 6000, -1000000250, 0);
    queue_rec(2147483647, 0, 0, 13);
    queue_rec(-1, -1, -1, 67108863);
    drain();

    for (p = 0; p < 10; p++) begin
      n_items = 170;
      no_idle = (p % 4 == 2);
      zone = $urandom_range(0, 1800);
      case (p)
        0: apply_windows(0, RA_TOP, 0, 0, POLAR_TOP, 0, 999, 1800);
        1: begin
          ra_lo = $urandom_range(64800000, RA_TOP);
          ra_hi = $urandom_range(0, 64800000);
          apply_windows(ra_lo, ra_hi, 1, 0, POLAR_TOP, 0, 999, zone);
          // Wrapping window: negative RA passes, oversized RA is kept truncated.
          queue_rec(-1, 100, 5, 1);
          queue_rec(2147483647, 100, 5, 2);
          queue_rec(ra_lo, 100, 5, 3);
          queue_rec(ra_hi, 100, 5, 4);
          queue_rec(ra_hi + 1, 100, 5, 5);
        end
        2: begin
          ra_lo = $urandom_range(0, 120000000);
          p_lo  = $urandom_range(0, 60000000);
          r_lo  = $urandom_range(0, 500);
          apply_windows(ra_lo, ra_lo + $urandom_range(0, 9600000), 0,
                        p_lo, p_lo + $urandom_range(0, 4800000),
                        r_lo, r_lo + $urandom_range(0, 499), zone);
        end
        3: begin
          // Inverted normal window keeps nothing.
          n_items = 60;
          apply_windows($urandom_range(70000000, RA_TOP), $urandom_range(0, 60000000), 0,
                        0, POLAR_TOP, 0, 999, zone);
        end
        4: apply_windows(0, RA_TOP, 0, 0, POLAR_TOP, 0, 0, 0);
        5: begin
          ra_lo = $urandom_range(0, RA_TOP);
          apply_windows(ra_lo, ra_lo, 0, 0, POLAR_TOP, 999, 999, 1800);
        end
        6: apply_windows(RA_TOP, 0, 1, POLAR_TOP, POLAR_TOP, 0, 999, zone);
        default: begin
          p_lo = $urandom_range(0, POLAR_TOP);
          r_lo = $urandom_range(0, 999);
          apply_windows($urandom_range(0, RA_TOP), $urandom_range(0, RA_TOP),
                        $urandom_range(0, 1), p_lo, $urandom_range(p_lo, POLAR_TOP),
                        r_lo, $urandom_range(r_lo, 999), zone);
        end
      endcase
      repeat (n_items) queue_random_rec();
      drain();
    end

    if (expected_stars.size() != 0) begin
      report_mismatch($sformatf("%0d kept records never came out", expected_stars.size()));
    end
    $display("Summary: %0d records sent under %0d window settings, %0d kept records checked.",
             records_sent, settings_used, stars_checked);
    $display("Summary: normal, wrapping, inverted and single-value windows plus raw noise.");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Input driver: presents queued records with a random gap between them, none when no_idle is set.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_in) begin
      if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_recs.size() != 0) begin
        s_tdata  <= {{S_FILL{1'b0}}, pending_recs.pop_front()};
        s_tvalid <= 1'b1;
        src_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        records_sent++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output stall: after each accepted result the receiver may hold off.
  always @(negedge clk) begin
    if (!rst) begin
      if (took_out) snk_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (snk_wait > 0) begin
        snk_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each accepted record, checks each accepted result.
  always @(posedge clk) begin : monitor
    star_rec_t seen_rec;
    star_res_t want, got;
    took_in  <= s_tvalid && s_tready;
    took_out <= m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      seen_rec = s_tdata[$bits(star_rec_t)-1:0];
      if (predict_kept_star(seen_rec, win_cfg, want)) expected_stars.push_back(want);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(star_res_t)-1:0];
      if (expected_stars.size() == 0) begin
        report_mismatch("result arrived with no kept record outstanding");
      end else begin
        want = expected_stars.pop_front();
        check_field("zone_out", got.zone_out, want.zone_out);
        check_field("index_out", got.index_out, want.index_out);
        check_field("ra_cas", got.ra_cas, want.ra_cas);
        check_field("polar_cas", got.polar_cas, want.polar_cas);
        check_field("act_sign", got.act_sign, want.act_sign);
        check_field("quality_flag", got.quality_flag, want.quality_flag);
        check_field("plate_field", got.plate_field, want.plate_field);
        check_field("blue_mag", got.blue_mag, want.blue_mag);
        check_field("red_mag", got.red_mag, want.red_mag);
      end
      stars_checked++;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
